// File: hw/rtl/ypvm_pkg.sv
package ypvm_pkg;

  localparam int COEF_FRACTION_BITS  = 14;
  localparam int ROTATION_ITERATIONS = 16;

  // angles in 1/128 degree
  localparam int DEG_360 = 46080;
  localparam int DEG_180 = 23040;
  localparam int DEG_90  = 11520;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0]        RAD_TO_DEG_Q22  = 32'd240315917;

  // row codes
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

  typedef struct packed {
    logic signed [17:0] ang;
    logic               flip;
  } fold_t;

  // one camera with its finished coefficients, [row][axis]
  typedef struct packed {
    logic [2:0][2:0][15:0] coef;
    logic [2:0][31:0]      pos;
    logic                  degen;
  } entry_t;

  // atan(2^-i) in degrees * 2^22
  function automatic logic signed [31:0] atan_step(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd188743680;
      1: v = 32'd111421900;
      2: v = 32'd58872272;
      3: v = 32'd29884485;
      4: v = 32'd15000234;
      5: v = 32'd7507429;
      6: v = 32'd3754631;
      7: v = 32'd1877430;
      default: v = RAD_TO_DEG_Q22 >> i;
    endcase
    return signed'(v);
  endfunction

endpackage

// File: hw/rtl/ypvm_cam_if.sv
interface ypvm_cam_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [16:0] yaw_angle;
  logic signed [16:0] pitch_angle;

  modport source (output valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle, output ready);
endinterface

// File: hw/rtl/ypvm_row_if.sv
interface ypvm_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [15:0] coef_x;
  logic signed [15:0] coef_y;
  logic signed [15:0] coef_z;
  logic signed [31:0] translation;
  logic               last_row;
  logic               degenerate;

  modport source (output valid, row_index, coef_x, coef_y, coef_z, translation,
                  last_row, degenerate, input ready);
  modport sink (input valid, row_index, coef_x, coef_y, coef_z, translation,
                last_row, degenerate, output ready);
endinterface

// File: hw/rtl/ypvm_cordic.sv
module ypvm_cordic #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] z_in,
  output logic               out_valid,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out
);
  import ypvm_pkg::*;

  logic               vs [0:ITERATIONS];
  logic signed [33:0] xs [0:ITERATIONS];
  logic signed [33:0] ys [0:ITERATIONS];
  logic signed [31:0] zs [0:ITERATIONS];

  assign vs[0] = in_valid;
  assign xs[0] = CORDIC_GAIN_Q30;
  assign ys[0] = '0;
  assign zs[0] = z_in;

  // one rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    localparam logic signed [31:0] AT = atan_step(i);
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - AT;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + AT;
      end
    end
  end

  assign out_valid = vs[ITERATIONS];
  assign x_out     = xs[ITERATIONS];
  assign y_out     = ys[ITERATIONS];
endmodule

// File: hw/rtl/ypvm_front.sv
module ypvm_front #(
  parameter int COEF_FRACTION_BITS  = ypvm_pkg::COEF_FRACTION_BITS,
  parameter int ROTATION_ITERATIONS = ypvm_pkg::ROTATION_ITERATIONS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       pos_x,
  input  logic [31:0]       pos_y,
  input  logic [31:0]       pos_z,
  input  logic [16:0]       yaw_angle,
  input  logic [16:0]       pitch_angle,
  output logic              push,
  output ypvm_pkg::entry_t  push_data
);
  import ypvm_pkg::*;

  localparam int N  = ROTATION_ITERATIONS;
  localparam int SH = 30 - COEF_FRACTION_BITS;
  localparam logic signed [35:0] RND = (SH == 0) ? 36'sd0 :
                                       (36'sd1 <<< ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [35:0] LIM = 36'sd1 <<< COEF_FRACTION_BITS;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic             yflip;
    logic             pflip;
    logic             degen;
  } side_t;

  // reduce to [-180,180) then fold into [-90,90]
  function automatic fold_t fold(input logic [16:0] raw);
    logic signed [18:0] a;
    fold_t r;
    a = 19'(signed'(raw));
    if (a < -DEG_360) a = a + 19'(2 * DEG_360);
    else if (a < 0) a = a + 19'(DEG_360);
    else if (a >= DEG_360) a = a - 19'(DEG_360);
    if (a >= DEG_180) a = a - 19'(DEG_360);
    r.flip = 1'b0;
    if (a > DEG_90) begin
      a = a - 19'(DEG_180);
      r.flip = 1'b1;
    end else if (a < -DEG_90) begin
      a = a + 19'(DEG_180);
      r.flip = 1'b1;
    end
    r.ang = a[17:0];
    return r;
  endfunction

  function automatic logic signed [34:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[64:30];
  endfunction

  function automatic logic [15:0] to_coef(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + RND) >>> SH;
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  // fold stage
  fold_t              yf, pf;
  logic               v0;
  logic signed [17:0] ya, pa;
  side_t              side0;

  assign yf = fold(yaw_angle);
  assign pf = fold(pitch_angle);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= in_valid;
    ya          <= yf.ang;
    pa          <= pf.ang;
    side0.pos   <= {pos_z, pos_y, pos_x};
    side0.yflip <= yf.flip;
    side0.pflip <= pf.flip;
    side0.degen <= (pf.ang == 18'(DEG_90)) || (pf.ang == -18'(DEG_90));
  end

  // sine/cosine pipelines, sideband follows in a matching delay line
  logic               cv, cv_p;
  logic signed [33:0] cyr, syr, cpf, spf;
  logic signed [31:0] zy, zp;
  side_t              side [0:N];

  assign zy = 32'(ya) <<< 15;
  assign zp = 32'(pa) <<< 15;

  ypvm_cordic #(.ITERATIONS(N)) u_yaw (
    .clk(clk), .rst(rst), .in_valid(v0), .z_in(zy),
    .out_valid(cv), .x_out(cyr), .y_out(syr)
  );
  ypvm_cordic #(.ITERATIONS(N)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(v0), .z_in(zp),
    .out_valid(cv_p), .x_out(cpf), .y_out(spf)
  );

  assign side[0] = side0;
  for (genvar i = 0; i < N; i++) begin : g_side
    always_ff @(posedge clk) side[i+1] <= side[i];
  end

  // sign correction stage
  logic               v1;
  logic signed [33:0] cy1, sy1, cpf1, spf1, cp1, sp1;
  side_t              s1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= cv & cv_p;
    cy1  <= side[N].yflip ? -cyr : cyr;
    sy1  <= side[N].yflip ? -syr : syr;
    cpf1 <= cpf;
    spf1 <= spf;
    cp1  <= side[N].pflip ? -cpf : cpf;
    sp1  <= side[N].pflip ? -spf : spf;
    s1   <= side[N];
  end

  // product stage
  logic               v2;
  logic signed [34:0] m_cs, m_ss, m_cc, m_sc;
  logic signed [33:0] cy2, sy2, cpf2, sp2;
  side_t              s2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    m_cs <= mul_q30(cy1, spf1);
    m_ss <= mul_q30(sy1, spf1);
    m_cc <= mul_q30(cy1, cp1);
    m_sc <= mul_q30(sy1, cp1);
    cy2  <= cy1;
    sy2  <= sy1;
    cpf2 <= cpf1;
    sp2  <= sp1;
    s2   <= s1;
  end

  // coefficient stage: rows right, up, minus forward
  logic signed [35:0] rv [0:2][0:2];
  always_comb begin
    rv[0][0] = s2.pflip ? 36'(sy2) : -36'(sy2);
    rv[0][1] = '0;
    rv[0][2] = s2.pflip ? -36'(cy2) : 36'(cy2);
    rv[1][0] = -36'(m_cs);
    rv[1][1] = 36'(cpf2);
    rv[1][2] = -36'(m_ss);
    rv[2][0] = -36'(m_cc);
    rv[2][1] = -36'(sp2);
    rv[2][2] = -36'(m_sc);
  end

  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else push <= v2;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        push_data.coef[r][k] <= s2.degen ? 16'd0 : to_coef(rv[r][k]);
      end
    end
    push_data.pos   <= s2.pos;
    push_data.degen <= s2.degen;
  end
endmodule

// File: hw/rtl/ypvm_queue.sv
module ypvm_queue #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ypvm_pkg::entry_t push_data,
  input  logic             pop,
  output logic             head_valid,
  output ypvm_pkg::entry_t head
);
  import ypvm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  entry_t           mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
endmodule

// File: hw/rtl/ypvm_back.sv
module ypvm_back #(
  parameter int COEF_FRACTION_BITS = ypvm_pkg::COEF_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  ypvm_pkg::entry_t head,
  output logic             pop,
  ypvm_row_if.source       row
);
  import ypvm_pkg::*;

  localparam logic signed [50:0] RND = 51'sd1 <<< (COEF_FRACTION_BITS - 1);

  logic [1:0]         row_cnt;
  logic               p_valid, p_degen;
  logic [1:0]         p_row;
  logic [2:0][15:0]   p_coef;
  logic signed [47:0] p_prod [0:2];
  logic               o_load, p_load;

  assign o_load = p_valid && (!row.valid || row.ready);
  assign p_load = head_valid && (!p_valid || o_load);
  assign pop    = p_load && (row_cnt == ROW_FWD);

  // row sequencing and coefficient-by-position products
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= ROW_RIGHT;
      p_valid <= 1'b0;
    end else begin
      if (p_load) row_cnt <= (row_cnt == ROW_FWD) ? ROW_RIGHT : row_cnt + 2'd1;
      if (p_load) p_valid <= 1'b1;
      else if (o_load) p_valid <= 1'b0;
    end
    if (p_load) begin
      p_row   <= row_cnt;
      p_degen <= head.degen;
      p_coef  <= head.coef[row_cnt];
      for (int k = 0; k < 3; k++) begin
        p_prod[k] <= signed'(head.coef[row_cnt][k]) * signed'(head.pos[k]);
      end
    end
  end

  // translation: negate, round half up, saturate
  logic signed [50:0] acc, rnd;
  logic signed [31:0] tr;
  always_comb begin
    acc = -(51'(p_prod[0]) + 51'(p_prod[1]) + 51'(p_prod[2]));
    rnd = (acc + RND) >>> COEF_FRACTION_BITS;
    if (rnd > 51'sd2147483647) tr = 32'sh7fffffff;
    else if (rnd < -51'sd2147483648) tr = 32'sh80000000;
    else tr = rnd[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) row.valid <= 1'b0;
    else if (o_load) row.valid <= 1'b1;
    else if (row.ready) row.valid <= 1'b0;
    if (o_load) begin
      row.row_index   <= p_row;
      row.coef_x      <= p_coef[0];
      row.coef_y      <= p_coef[1];
      row.coef_z      <= p_coef[2];
      row.translation <= tr;
      row.last_row    <= (p_row == ROW_FWD);
      row.degenerate  <= p_degen;
    end
  end
endmodule

// File: hw/rtl/yaw_pitch_view_matrix_core.sv
// A camera passes the fold register, the CORDIC stages, the sign, product and
// coefficient registers, the queue and the back's registers before its first row.
// A camera's three rows share one port, one per cycle unless row.ready stalls.
// The front (fold, CORDIC, products) is fully pipelined and never stalls.
// Reset (synchronous, active high) clears valid bits, queue pointers and counters.
module yaw_pitch_view_matrix_core #(
  parameter int COEF_FRACTION_BITS  = ypvm_pkg::COEF_FRACTION_BITS,
  parameter int ROTATION_ITERATIONS = ypvm_pkg::ROTATION_ITERATIONS
) (
  input logic       clk,
  input logic       rst,
  ypvm_cam_if.sink  cam,
  ypvm_row_if.source row
);
  import ypvm_pkg::*;

  localparam int QDEPTH = 2 ** $clog2((ROTATION_ITERATIONS + 4) / 3 + 3);
  localparam int CW     = $clog2(QDEPTH + 1);

  logic        accept, push, pop, head_valid;
  entry_t      push_data, head;
  logic [CW-1:0] inflight;

  // credit: cameras in the front pipeline plus queue never exceed its depth
  assign cam.ready = (inflight < CW'(QDEPTH));
  assign accept    = cam.valid && cam.ready;

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= inflight + CW'(accept) - CW'(pop);
  end

  ypvm_front #(
    .COEF_FRACTION_BITS(COEF_FRACTION_BITS),
    .ROTATION_ITERATIONS(ROTATION_ITERATIONS)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(accept),
    .pos_x(cam.pos_x), .pos_y(cam.pos_y), .pos_z(cam.pos_z),
    .yaw_angle(cam.yaw_angle), .pitch_angle(cam.pitch_angle),
    .push(push), .push_data(push_data)
  );

  ypvm_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  ypvm_back #(.COEF_FRACTION_BITS(COEF_FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head),
    .pop(pop), .row(row)
  );
endmodule

// File: dv/ypvm_checker.sv
`timescale 1ns / 1ps

module ypvm_checker
  import ypvm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  ypvm_cam_if   cam,
  ypvm_row_if   row,
  output int    bad_rows,
  output int    rows_pending
);

  typedef struct {
    logic [1:0]         idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic signed [31:0] tr;
    logic               last;
    logic               degen;
  } view_row_t;

  view_row_t pending_rows[$];

  // atan(2^-i) in degrees, Q22
  function automatic longint atan_deg(int i);
    longint head[8] = '{188743680, 111421900, 58872272, 29884485,
                        15000234, 7507429, 3754631, 1877430};
    if (i < 8) return head[i];
    return longint'(RAD_TO_DEG_Q22 >> i);
  endfunction

  // wrap to [-180,180) then fold into [-90,90]; flip marks a 180 degree turn
  function automatic void fold(input logic signed [16:0] raw, output int a,
                               output bit flip);
    a = raw;
    flip = 0;
    a = a % DEG_360;
    if (a < 0) a += DEG_360;
    if (a >= DEG_180) a -= DEG_360;
    if (a > DEG_90) begin
      a -= DEG_180;
      flip = 1;
    end else if (a < -DEG_90) begin
      a += DEG_180;
      flip = 1;
    end
  endfunction

  // rotation-mode sine/cosine, Q30 out
  function automatic void sin_cos(input int ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = longint'(ang) * 32768;
    for (int i = 0; i < ROTATION_ITERATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_deg(i);
      end else begin
        x += dx; y -= dy; z += atan_deg(i);
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint mul30(longint a, longint b);
    return (a * b + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic longint q30_to_coef(longint v);
    longint lim;
    int sh;
    lim = longint'(1) << COEF_FRACTION_BITS;
    sh = 30 - COEF_FRACTION_BITS;
    if (sh > 0) v = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  // three view matrix rows for one camera
  task automatic predict_view_rows(logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] pz, logic signed [16:0] yaw,
                                   logic signed [16:0] pitch);
    int ya, pa;
    bit yflip, pflip, degen;
    longint cy, sy, cpf, spf, cp, sp, acc, t;
    longint m[3][3];
    longint c[3];
    longint p[3];
    view_row_t e;
    p[0] = px; p[1] = py; p[2] = pz;
    fold(yaw, ya, yflip);
    fold(pitch, pa, pflip);
    degen = (pa == DEG_90) || (pa == -DEG_90);
    sin_cos(ya, cy, sy);
    if (yflip) begin
      cy = -cy; sy = -sy;
    end
    sin_cos(pa, cpf, spf);
    cp = pflip ? -cpf : cpf;
    sp = pflip ? -spf : spf;
    m[0][0] = pflip ? sy : -sy;
    m[0][1] = 0;
    m[0][2] = pflip ? -cy : cy;
    m[1][0] = -mul30(cy, spf);
    m[1][1] = cpf;
    m[1][2] = -mul30(sy, spf);
    m[2][0] = -mul30(cy, cp);
    m[2][1] = -sp;
    m[2][2] = -mul30(sy, cp);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        c[k] = degen ? 0 : q30_to_coef(m[r][k]);
        acc += c[k] * p[k];
      end
      t = (-acc + (longint'(1) << (COEF_FRACTION_BITS - 1))) >>> COEF_FRACTION_BITS;
      if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
      if (t < -64'sh80000000) t = -64'sh80000000;
      e.idx   = (r == 0) ? ROW_RIGHT : (r == 1) ? ROW_UP : ROW_FWD;
      e.cx    = c[0][15:0];
      e.cy    = c[1][15:0];
      e.cz    = c[2][15:0];
      e.tr    = t[31:0];
      e.last  = (r == 2);
      e.degen = degen;
      pending_rows.push_back(e);
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      bad_rows++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  assign rows_pending = pending_rows.size();

  // camera transfers feed the prediction, row transfers are checked in order
  always @(posedge clk) begin
    view_row_t e;
    if (rst) begin
      bad_rows = 0;
    end else begin
      if (cam.valid && cam.ready)
        predict_view_rows(cam.pos_x, cam.pos_y, cam.pos_z, cam.yaw_angle, cam.pitch_angle);
      if (row.valid && row.ready) begin
        if (pending_rows.size() == 0) begin
          bad_rows++;
          $display("%0t: row transfer with none expected, row_index %0d", $time,
                   row.row_index);
        end else begin
          e = pending_rows.pop_front();
          check_field("row_index", e.idx, row.row_index);
          check_field("coef_x", e.cx, row.coef_x);
          check_field("coef_y", e.cy, row.coef_y);
          check_field("coef_z", e.cz, row.coef_z);
          check_field("translation", e.tr, row.translation);
          check_field("last_row", e.last, row.last_row);
          check_field("degenerate", e.degen, row.degenerate);
        end
      end
    end
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ypvm_pkg::*;

  logic clk;
  logic rst;
  int   bad_rows;
  int   rows_pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_requests;
  int   quiet_cycles;

  ypvm_cam_if cam();
  ypvm_row_if row();

  yaw_pitch_view_matrix_core i_dut (
    .clk (clk),
    .rst (rst),
    .cam (cam),
    .row (row)
  );

  ypvm_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cam          (cam),
    .row          (row),
    .bad_rows     (bad_rows),
    .rows_pending (rows_pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // one camera transfer; optional idle gap first
  task automatic send_camera(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic signed [16:0] yaw, logic signed [16:0] pitch);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cam.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cam.valid       <= 1;
    cam.pos_x       <= px;
    cam.pos_y       <= py;
    cam.pos_z       <= pz;
    cam.yaw_angle   <= yaw;
    cam.pitch_angle <= pitch;
    @(posedge clk);
    while (!cam.ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(65536 * 8)) - 65536 * 4);
      default: return $urandom;
    endcase
  endfunction

  // mostly uniform angles, some near multiples of 45 degrees
  function automatic logic signed [16:0] rand_angle();
    int a;
    if ($urandom_range(9) < 7) a = int'($urandom_range(2 * DEG_360)) - DEG_360;
    else a = (int'($urandom_range(16)) - 8) * (DEG_90 / 2) + int'($urandom_range(4)) - 2;
    if (a > DEG_360) a = DEG_360;
    if (a < -DEG_360) a = -DEG_360;
    return 17'(a);
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    static int hold_left = 0;
    static int served = 0;
    if (served != hold_requests) begin
      served = hold_requests;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      row.ready <= 0;
    end else begin
      row.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (cam.valid && cam.ready) || (row.valid && row.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [16:0] angles[12];
    logic [31:0] edge_pos[4];
    angles = '{17'sd0, 17'sd11520, -17'sd11520, 17'sd23040, -17'sd23040, 17'sd46080,
               -17'sd46080, 17'sd34560, 17'sd5760, 17'sd1, -17'sd1, 17'sd11519};
    edge_pos = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
    rst = 1;
    cam.valid = 0;
    cam.pos_x = 0;
    cam.pos_y = 0;
    cam.pos_z = 0;
    cam.yaw_angle = 0;
    cam.pitch_angle = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: angle corners, degenerate pitch, position extremes
    for (int i = 0; i < 12; i++)
      send_camera(edge_pos[i % 4], edge_pos[(i + 1) % 4], edge_pos[(i + 2) % 4],
                  angles[i], angles[(i + 5) % 12]);
    for (int i = 0; i < 8; i++)
      send_camera(edge_pos[i % 4], edge_pos[(i + 3) % 4], edge_pos[(i + 1) % 4],
                  angles[(i + 3) % 12], angles[i % 12]);

    // random phases: none (plus one long receiver hold-off), sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 26 : 0;
      for (int n = 0; n < 78; n++) begin
        if (ph == 0 && n == 20) hold_requests++;
        if (ph == 1 && n == 40) begin
          cam.valid <= 0;
          // let the checker record the last transfer before draining
          @(posedge clk);
          wait (rows_pending == 0);
          @(posedge clk);
        end
        send_camera(rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle());
      end
    end
    cam.valid <= 0;

    @(posedge clk);
    wait (rows_pending == 0);
    repeat (40) @(posedge clk);
    if (bad_rows == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
